FILE: sv/skf_pkg.sv
// Shared types and constants for the scan code to character FIFO block.
// Holds the transaction structs, the set-1 modifier codes and the four character banks.
// No dependencies.
package skf_pkg;

	// Request kinds carried in req_type
	localparam logic REQ_SCAN = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// Set-1 make codes of the modifier keys
	localparam logic [6:0] CODE_LSHIFT = 7'h2A;
	localparam logic [6:0] CODE_RSHIFT = 7'h36;
	localparam logic [6:0] CODE_CTRL   = 7'h1D;
	localparam logic [6:0] CODE_ALT    = 7'h38;

	// Codes at or above this have no table entry
	localparam logic [6:0] ROM_KEYS = 7'd90;
	// Table marker for a key that produces no character
	localparam logic [7:0] NO_CHAR  = 8'hFF;

	// Bit positions in the modifier register
	localparam int MOD_LSHIFT = 0;
	localparam int MOD_RSHIFT = 1;
	localparam int MOD_CTRL   = 2;
	localparam int MOD_ALT    = 3;

	typedef struct packed {
		logic       req_type;
		logic [7:0] scan_byte;
	} cmd_t;

	typedef struct packed {
		logic [7:0] key_char;
		logic       key_valid;
		logic       keys_waiting;
		logic       key_dropped;
	} res_t;

	// Unshifted bank
	localparam logic [7:0] ROM_NORMAL [90] = '{
		8'hFF, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
		8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
		8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'hFF,
		8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h60, 8'hFF, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
		8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'hFF, 8'hFF, 8'hFF, 8'h20, 8'hFF, 8'hAF,
		8'hB0, 8'hB1, 8'hB2, 8'hB3, 8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB8, 8'hFF,
		8'hFF, 8'hBC, 8'hBD, 8'hBE, 8'h2D, 8'hBF, 8'hC0, 8'hC1, 8'h2B, 8'hC2,
		8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hFF, 8'hFF, 8'hFF, 8'hB9, 8'hBA, 8'hFF
	};

	// Shift bank
	localparam logic [7:0] ROM_SHIFT [90] = '{
		8'hFF, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
		8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
		8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'hFF,
		8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
		8'h22, 8'h7E, 8'hFF, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
		8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'hFF, 8'hFF, 8'hFF, 8'h20, 8'hFF, 8'hC7,
		8'hC8, 8'hC9, 8'hCA, 8'hCB, 8'hCC, 8'hCD, 8'hCE, 8'hCF, 8'hD0, 8'hFF,
		8'hFF, 8'hD3, 8'hD4, 8'hD5, 8'h2D, 8'hD6, 8'hD7, 8'hD8, 8'h2B, 8'hD9,
		8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hFF, 8'hFF, 8'hFF, 8'hD1, 8'hD2, 8'hFF
	};

	// Control bank
	localparam logic [7:0] ROM_CTRL [90] = '{
		8'hFF, 8'h1B, 8'h7F, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86,
		8'h87, 8'h88, 8'h89, 8'h1F, 8'h08, 8'h09, 8'h11, 8'h17, 8'h05, 8'h12,
		8'h14, 8'h19, 8'h15, 8'h09, 8'h0F, 8'h10, 8'h1E, 8'h1D, 8'h0D, 8'hFF,
		8'h01, 8'h13, 8'h04, 8'h06, 8'h07, 8'h08, 8'h0A, 8'h0B, 8'h0C, 8'h8A,
		8'h1C, 8'hFF, 8'hFF, 8'hFF, 8'h1A, 8'h18, 8'h03, 8'h16, 8'h02, 8'h0E,
		8'h0D, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h20, 8'hFF, 8'hDE,
		8'hDF, 8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hE6, 8'hE7, 8'hFF,
		8'hFF, 8'hEA, 8'hEB, 8'hEC, 8'h2D, 8'hED, 8'hEE, 8'hEF, 8'h2B, 8'hF0,
		8'hF1, 8'hF2, 8'hF3, 8'hF4, 8'hFF, 8'hFF, 8'hFF, 8'hE8, 8'hE9, 8'hFF
	};

	// Alt bank
	localparam logic [7:0] ROM_ALT [90] = '{
		8'hFF, 8'h1B, 8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91, 8'h92,
		8'h93, 8'h94, 8'hFF, 8'hFF, 8'h08, 8'h09, 8'h95, 8'h96, 8'h97, 8'h98,
		8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9D, 8'h9E, 8'hFF, 8'hFF, 8'h0D, 8'hFF,
		8'h9F, 8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'hA4, 8'hA5, 8'hA6, 8'hA7, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hA8, 8'hA9, 8'hAA, 8'hAB, 8'hAC, 8'hAD,
		8'hAE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h20, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hF5, 8'hF6, 8'hF7, 8'h2D, 8'hF8, 8'hF9, 8'hFA, 8'h2B, 8'hFB,
		8'hFC, 8'hFD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
	};

endpackage

FILE: sv/scancode_to_ascii_key_fifo.sv
// Top level: set-1 scan byte decoder feeding a character FIFO held in a synchronous memory.
// Depends on skf_pkg for the transaction structs, key codes and character banks.
//
// Takes one transaction per clock: either a raw scan byte (bit 7 = release) or a request to
// read one character. Modifier make/break codes update the shift, control and alt flags; any
// other make is looked up in the character bank picked by alt, then control, then shift, and
// the character is pushed into a FIFO of FIFO_DEPTH slots holding at most FIFO_DEPTH-1
// characters. A key that arrives on a full FIFO is dropped and flagged. A read pops the
// oldest character or reports none. Every transaction gives exactly one result, through
// the registered read of the FIFO memory and then the output register. Sustained rate is
// one transaction per cycle, set by the single read and single write port of the FIFO
// memory. The input stalls only while the memory read stage holds a result that the
// stalled output register cannot yet take.
module scancode_to_ascii_key_fifo #(
	parameter int FIFO_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  skf_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output skf_pkg::res_t res
);
	import skf_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

	// State registers
	logic [3:0]       mod_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;

	// FIFO storage
	logic [7:0] fifo_mem [FIFO_DEPTH];

	// Memory read stage
	logic       valid_s1;
	logic [7:0] rd_data_s1;
	logic       key_valid_s1;
	logic       waiting_s1;
	logic       dropped_s1;

	// Output register
	logic out_valid_q;
	res_t out_q;

	logic             accept;
	logic             advance_s1;
	logic             is_read;
	logic [6:0]       code;
	logic             release_key;
	logic [3:0]       mod_bit;
	logic [6:0]       rom_idx;
	logic [7:0]       rom_char;
	logic [PTR_W-1:0] rd_ptr_inc;
	logic [PTR_W-1:0] wr_ptr_inc;
	logic [PTR_W-1:0] rd_ptr_next;
	logic [PTR_W-1:0] wr_ptr_next;
	logic             not_empty;
	logic             mapped;
	logic             fifo_full;
	logic             pop;
	logic             push;
	logic             drop;
	logic             waiting;
	logic [3:0]       mod_next;

	// Handshake: read stage moves on when the output register is free or being emptied
	assign advance_s1 = !out_valid_q || !res_stall;
	assign cmd_stall  = valid_s1 && !advance_s1;
	assign accept     = cmd_valid && !cmd_stall;

	assign is_read     = (cmd.req_type == REQ_READ);
	assign code        = cmd.scan_byte[6:0];
	assign release_key = cmd.scan_byte[7];

	// Modifier decode
	always_comb begin
		mod_bit = '0;
		priority if (code == CODE_LSHIFT) begin
			mod_bit[MOD_LSHIFT] = 1'b1;
		end else if (code == CODE_RSHIFT) begin
			mod_bit[MOD_RSHIFT] = 1'b1;
		end else if (code == CODE_CTRL) begin
			mod_bit[MOD_CTRL] = 1'b1;
		end else if (code == CODE_ALT) begin
			mod_bit[MOD_ALT] = 1'b1;
		end else begin
			mod_bit = '0;
		end
	end

	// Character lookup: bank by modifier priority
	assign rom_idx = (code < ROM_KEYS) ? code : '0;

	always_comb begin
		priority if (mod_q[MOD_ALT]) begin
			rom_char = ROM_ALT[rom_idx];
		end else if (mod_q[MOD_CTRL]) begin
			rom_char = ROM_CTRL[rom_idx];
		end else if (mod_q[MOD_LSHIFT] || mod_q[MOD_RSHIFT]) begin
			rom_char = ROM_SHIFT[rom_idx];
		end else begin
			rom_char = ROM_NORMAL[rom_idx];
		end
	end

	// Pointer arithmetic, wrapping at FIFO_DEPTH
	assign rd_ptr_inc = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
	assign wr_ptr_inc = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
	assign not_empty  = (rd_ptr_q != wr_ptr_q);
	assign fifo_full  = (wr_ptr_inc == rd_ptr_q);

	// Transaction decisions
	assign pop    = accept && is_read && not_empty;
	assign mapped = accept && !is_read && (mod_bit == '0) && !release_key
		&& (code < ROM_KEYS) && (rom_char != NO_CHAR);
	assign push   = mapped && !fifo_full;
	assign drop   = mapped && fifo_full;

	assign rd_ptr_next = pop  ? rd_ptr_inc : rd_ptr_q;
	assign wr_ptr_next = push ? wr_ptr_inc : wr_ptr_q;
	assign waiting     = (rd_ptr_next != wr_ptr_next);

	// Modifier update
	always_comb begin
		mod_next = mod_q;
		if (accept && !is_read) begin
			if (release_key) begin
				mod_next = mod_q & ~mod_bit;
			end else begin
				mod_next = mod_q | mod_bit;
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q       <= '0;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mod_q    <= mod_next;
			rd_ptr_q <= rd_ptr_next;
			wr_ptr_q <= wr_ptr_next;
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance_s1) begin
				valid_s1 <= 1'b0;
			end
			if (advance_s1) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// FIFO memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_mem[wr_ptr_q] <= rom_char;
		end
		if (pop) begin
			rd_data_s1 <= fifo_mem[rd_ptr_q];
		end
	end

	// Read stage sideband
	always_ff @(posedge clk) begin
		if (accept) begin
			key_valid_s1 <= pop;
			waiting_s1   <= waiting;
			dropped_s1   <= drop;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (advance_s1 && valid_s1) begin
			out_q.key_char     <= key_valid_s1 ? rd_data_s1 : 8'h00;
			out_q.key_valid    <= key_valid_s1;
			out_q.keys_waiting <= waiting_s1;
			out_q.key_dropped  <= dropped_s1;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

FILE: test/tb.sv
// Self-checking testbench for scancode_to_ascii_key_fifo: directed keystrokes, then random traffic.
// Predicts every result with its own keyboard model and character map; needs skf_pkg and the block.
`timescale 1ns / 100ps

module tb;
	import skf_pkg::*;

	localparam int CLK_HALF    = 10;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 1950;
	localparam int PHASES      = 4;
	localparam int DRAIN_CYCLES = 10;

	// Character banks, in priority order of the modifiers that select them
	localparam int BANK_NORMAL = 0;
	localparam int BANK_SHIFT  = 1;
	localparam int BANK_CTRL   = 2;
	localparam int BANK_ALT    = 3;
	localparam int BANK_KEYS   = 90;

	// Four banks of 90 entries, normal / shift / control / alt
	localparam logic [7:0] KEY_MAP [360] = '{
		8'hFF, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
		8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
		8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'hFF,
		8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h60, 8'hFF, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
		8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'hFF, 8'hFF, 8'hFF, 8'h20, 8'hFF, 8'hAF,
		8'hB0, 8'hB1, 8'hB2, 8'hB3, 8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB8, 8'hFF,
		8'hFF, 8'hBC, 8'hBD, 8'hBE, 8'h2D, 8'hBF, 8'hC0, 8'hC1, 8'h2B, 8'hC2,
		8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hFF, 8'hFF, 8'hFF, 8'hB9, 8'hBA, 8'hFF,

		8'hFF, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
		8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
		8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'hFF,
		8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
		8'h22, 8'h7E, 8'hFF, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
		8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'hFF, 8'hFF, 8'hFF, 8'h20, 8'hFF, 8'hC7,
		8'hC8, 8'hC9, 8'hCA, 8'hCB, 8'hCC, 8'hCD, 8'hCE, 8'hCF, 8'hD0, 8'hFF,
		8'hFF, 8'hD3, 8'hD4, 8'hD5, 8'h2D, 8'hD6, 8'hD7, 8'hD8, 8'h2B, 8'hD9,
		8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hFF, 8'hFF, 8'hFF, 8'hD1, 8'hD2, 8'hFF,

		8'hFF, 8'h1B, 8'h7F, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86,
		8'h87, 8'h88, 8'h89, 8'h1F, 8'h08, 8'h09, 8'h11, 8'h17, 8'h05, 8'h12,
		8'h14, 8'h19, 8'h15, 8'h09, 8'h0F, 8'h10, 8'h1E, 8'h1D, 8'h0D, 8'hFF,
		8'h01, 8'h13, 8'h04, 8'h06, 8'h07, 8'h08, 8'h0A, 8'h0B, 8'h0C, 8'h8A,
		8'h1C, 8'hFF, 8'hFF, 8'hFF, 8'h1A, 8'h18, 8'h03, 8'h16, 8'h02, 8'h0E,
		8'h0D, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h20, 8'hFF, 8'hDE,
		8'hDF, 8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hE6, 8'hE7, 8'hFF,
		8'hFF, 8'hEA, 8'hEB, 8'hEC, 8'h2D, 8'hED, 8'hEE, 8'hEF, 8'h2B, 8'hF0,
		8'hF1, 8'hF2, 8'hF3, 8'hF4, 8'hFF, 8'hFF, 8'hFF, 8'hE8, 8'hE9, 8'hFF,

		8'hFF, 8'h1B, 8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91, 8'h92,
		8'h93, 8'h94, 8'hFF, 8'hFF, 8'h08, 8'h09, 8'h95, 8'h96, 8'h97, 8'h98,
		8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9D, 8'h9E, 8'hFF, 8'hFF, 8'h0D, 8'hFF,
		8'h9F, 8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'hA4, 8'hA5, 8'hA6, 8'hA7, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hA8, 8'hA9, 8'hAA, 8'hAB, 8'hAC, 8'hAD,
		8'hAE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h20, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hF5, 8'hF6, 8'hF7, 8'h2D, 8'hF8, 8'hF9, 8'hFA, 8'h2B, 8'hFB,
		8'hFC, 8'hFD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
	};

	// Directed row: keystroke, whether the result is written out, and that result
	typedef struct packed {
		cmd_t stroke;
		logic typed;
		res_t want;
	} stroke_row_t;

	localparam res_t QUIET_EMPTY   = '{8'h00, 1'b0, 1'b0, 1'b0};
	localparam res_t QUIET_WAITING = '{8'h00, 1'b0, 1'b1, 1'b0};
	localparam res_t FIRST_A       = '{8'h61, 1'b1, 1'b1, 1'b0};

	localparam int DIRECTED_ROWS = 27;
	localparam stroke_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{'{REQ_READ, 8'h00}, 1'b1, QUIET_EMPTY},    // read while empty
		'{'{REQ_SCAN, 8'h00}, 1'b1, QUIET_EMPTY},    // code with no character
		'{'{REQ_SCAN, 8'hDA}, 1'b1, QUIET_EMPTY},    // release of an unmapped key
		'{'{REQ_SCAN, 8'h5A}, 1'b1, QUIET_EMPTY},    // first code past the table
		'{'{REQ_SCAN, 8'h7F}, 1'b1, QUIET_EMPTY},    // top code
		'{'{REQ_SCAN, 8'h1E}, 1'b0, QUIET_EMPTY},    // 'a'
		'{'{REQ_SCAN, 8'h2A}, 1'b1, QUIET_WAITING},  // left shift make
		'{'{REQ_SCAN, 8'h2A}, 1'b1, QUIET_WAITING},  // repeated make
		'{'{REQ_SCAN, 8'h1E}, 1'b0, QUIET_EMPTY},    // 'A'
		'{'{REQ_SCAN, 8'hAA}, 1'b1, QUIET_WAITING},  // left shift break
		'{'{REQ_SCAN, 8'h36}, 1'b1, QUIET_WAITING},  // right shift make
		'{'{REQ_SCAN, 8'h02}, 1'b0, QUIET_EMPTY},    // '!'
		'{'{REQ_SCAN, 8'hB6}, 1'b1, QUIET_WAITING},  // right shift break
		'{'{REQ_SCAN, 8'hB6}, 1'b1, QUIET_WAITING},  // break of a clear modifier
		'{'{REQ_SCAN, 8'h1D}, 1'b1, QUIET_WAITING},  // control make
		'{'{REQ_SCAN, 8'h2A}, 1'b1, QUIET_WAITING},  // shift under control
		'{'{REQ_SCAN, 8'h02}, 1'b0, QUIET_EMPTY},    // control bank wins over shift
		'{'{REQ_SCAN, 8'h38}, 1'b1, QUIET_WAITING},  // alt make
		'{'{REQ_SCAN, 8'h02}, 1'b0, QUIET_EMPTY},    // alt bank wins over all
		'{'{REQ_SCAN, 8'h59}, 1'b1, QUIET_WAITING},  // last code, no alt character
		'{'{REQ_SCAN, 8'h9E}, 1'b1, QUIET_WAITING},  // release of a plain key
		'{'{REQ_SCAN, 8'hFF}, 1'b1, QUIET_WAITING},  // all ones
		'{'{REQ_SCAN, 8'hB8}, 1'b1, QUIET_WAITING},  // alt break
		'{'{REQ_SCAN, 8'h9D}, 1'b1, QUIET_WAITING},  // control break
		'{'{REQ_SCAN, 8'hAA}, 1'b1, QUIET_WAITING},  // left shift break
		'{'{REQ_READ, 8'hFF}, 1'b1, FIRST_A},        // oldest character first
		'{'{REQ_READ, 8'h00}, 1'b0, QUIET_EMPTY}
	};

	logic clk;
	logic arst_n     = 1'b0;
	logic cmd_valid  = 1'b0;
	logic cmd_stall;
	cmd_t cmd        = '0;
	logic res_valid;
	logic res_stall  = 1'b0;
	res_t res;

	// Keyboard model state
	logic [3:0] mod_keys;
	logic [3:0] head_idx;
	logic [3:0] tail_idx;
	logic [7:0] char_queue [16];

	res_t results_due [$];
	int   idle_pct   = 0;
	int   stall_pct  = 0;
	int   accepted   = 0;
	int   mismatches = 0;
	int   chars_read = 0;
	int   keys_lost  = 0;
	int   cycles     = 0;

	scancode_to_ascii_key_fifo dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Advance the keyboard model by one transaction and return its result
	function automatic res_t keyboard_step(cmd_t c);
		res_t       r;
		logic [6:0] code;
		logic [3:0] mod_bit;
		logic [7:0] ch;
		int         bank;
		r = '0;
		if (c.req_type == REQ_READ) begin
			if (head_idx != tail_idx) begin
				r.key_char  = char_queue[head_idx];
				r.key_valid = 1'b1;
				head_idx    = head_idx + 4'd1;
			end
		end else begin
			code = c.scan_byte[6:0];
			case (code)
				CODE_LSHIFT: mod_bit = 4'(1) << MOD_LSHIFT;
				CODE_RSHIFT: mod_bit = 4'(1) << MOD_RSHIFT;
				CODE_CTRL:   mod_bit = 4'(1) << MOD_CTRL;
				CODE_ALT:    mod_bit = 4'(1) << MOD_ALT;
				default:     mod_bit = '0;
			endcase
			if (mod_bit != '0) begin
				mod_keys = c.scan_byte[7] ? (mod_keys & ~mod_bit) : (mod_keys | mod_bit);
			end else if (!c.scan_byte[7] && code < ROM_KEYS) begin
				if (mod_keys[MOD_ALT])
					bank = BANK_ALT;
				else if (mod_keys[MOD_CTRL])
					bank = BANK_CTRL;
				else if (mod_keys[MOD_LSHIFT] || mod_keys[MOD_RSHIFT])
					bank = BANK_SHIFT;
				else
					bank = BANK_NORMAL;
				ch = KEY_MAP[bank * BANK_KEYS + int'(code)];
				if (ch != NO_CHAR) begin
					// one slot stays empty so full and empty differ
					if (tail_idx + 4'd1 == head_idx) begin
						r.key_dropped = 1'b1;
					end else begin
						char_queue[tail_idx] = ch;
						tail_idx = tail_idx + 4'd1;
					end
				end
			end
		end
		r.keys_waiting = (head_idx != tail_idx);
		return r;
	endfunction

	// Mostly well-formed typing: modifier make/break, key makes, some reads and raw noise
	function automatic cmd_t random_stroke(int read_pct);
		cmd_t c;
		int   pick;
		int   which;
		c.scan_byte = 8'($urandom);
		c.req_type  = REQ_SCAN;
		if ($urandom_range(99) < read_pct) begin
			c.req_type = REQ_READ;
		end else begin
			pick = $urandom_range(99);
			if (pick < 20) begin
				which = $urandom_range(3);
				case (which)
					0:       c.scan_byte[6:0] = CODE_LSHIFT;
					1:       c.scan_byte[6:0] = CODE_RSHIFT;
					2:       c.scan_byte[6:0] = CODE_CTRL;
					default: c.scan_byte[6:0] = CODE_ALT;
				endcase
				// breaks a bit more often so plain banks still get traffic
				c.scan_byte[7] = ($urandom_range(99) < 60);
			end else if (pick < 85) begin
				c.scan_byte = {1'b0, 7'($urandom_range(BANK_KEYS - 1))};
			end
		end
		return c;
	endfunction

	// Present one transaction from a falling edge; returns at the falling edge after acceptance
	task automatic offer(cmd_t c, logic typed, res_t want);
		res_t predicted;
		while ($urandom_range(99) < idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		predicted = keyboard_step(c);
		results_due.push_back(typed ? want : predicted);
		accepted++;
		@(negedge clk);
	endtask

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Receiver back pressure
	always @(negedge clk)
		res_stall <= ($urandom_range(99) < stall_pct);

	// Result checking and run-time guard
	always @(posedge clk) begin
		res_t want;
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t ns: timeout with %0d results outstanding", $time, results_due.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
		if (arst_n === 1'b1 && res_valid === 1'b1 && !res_stall) begin
			if (results_due.size() == 0) begin
				$display("%0t ns: result with none outstanding, got char %0h valid %0b",
					$time, res.key_char, res.key_valid);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				check_field("key_char", want.key_char, res.key_char);
				check_field("key_valid", 8'(want.key_valid), 8'(res.key_valid));
				check_field("keys_waiting", 8'(want.keys_waiting), 8'(res.keys_waiting));
				check_field("key_dropped", 8'(want.key_dropped), 8'(res.key_dropped));
				if (want.key_valid)
					chars_read++;
				if (want.key_dropped)
					keys_lost++;
			end
		end
	end

	// Stimulus: reset, directed table, then random typing under four idle/stall mixes
	initial begin
		int idle_by_phase  [PHASES];
		int stall_by_phase [PHASES];
		int per_phase;
		idle_by_phase  = '{0, 59, 0, 36};
		stall_by_phase = '{0, 0, 59, 36};
		mod_keys = '0;
		head_idx = '0;
		tail_idx = '0;
		foreach (char_queue[i])
			char_queue[i] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++)
			offer(DIRECTED[i].stroke, DIRECTED[i].typed, DIRECTED[i].want);

		per_phase = RANDOM_ITEMS / PHASES;
		for (int p = 0; p < PHASES; p++) begin
			idle_pct  = idle_by_phase[p];
			stall_pct = stall_by_phase[p];
			// alternate fill-heavy and drain-heavy stretches to reach full and empty
			for (int i = 0; i < per_phase; i++)
				offer(random_stroke(((i / 60) % 2) ? 75 : 8), 1'b0, QUIET_EMPTY);
		end
		cmd_valid <= 1'b0;

		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d transactions (%0d directed) under four idle and stall mixes",
			accepted, DIRECTED_ROWS);
		$display("Characters read back: %0d, keys lost on a full queue: %0d",
			chars_read, keys_lost);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
